// ----- src/lsht_pkg.sv -----
package lsht_pkg;

    localparam int CoordW    = 24;
    localparam int ThickW    = 16;
    localparam int DistW     = 25;
    localparam int DiffW     = CoordW + 1;
    localparam int ProdW     = 2 * DiffW;
    localparam int MagW      = 50;
    localparam int AccW      = MagW + DistW;
    localparam int RemW      = 2 * MagW;
    localparam int CfgIndexW = 3;

    localparam int LSHT_QUEUE_DEPTH = 2;

    localparam logic signed [CoordW-1:0] CoordMax = 24'sh7FFFFF;
    localparam logic signed [CoordW-1:0] CoordMin = -24'sh800000;

    typedef enum logic [CfgIndexW-1:0] {
        REG_CURSOR_X = 3'd0,
        REG_CURSOR_Y = 3'd1,
        REG_SEL_A_X  = 3'd2,
        REG_SEL_A_Y  = 3'd3,
        REG_SEL_B_X  = 3'd4,
        REG_SEL_B_Y  = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [CoordW-1:0] cursor_x;
        logic signed [CoordW-1:0] cursor_y;
        logic signed [CoordW-1:0] sel_a_x;
        logic signed [CoordW-1:0] sel_a_y;
        logic signed [CoordW-1:0] sel_b_x;
        logic signed [CoordW-1:0] sel_b_y;
    } cfg_t;

    typedef struct packed {
        logic                     kind;
        logic signed [CoordW-1:0] start_x;
        logic signed [CoordW-1:0] start_y;
        logic signed [CoordW-1:0] end_x;
        logic signed [CoordW-1:0] end_y;
        logic        [ThickW-1:0] thickness;
    } seg_in_t;

    typedef struct packed {
        logic        [DistW-1:0]  distance;
        logic                     selected;
        logic signed [CoordW-1:0] box_min_x;
        logic signed [CoordW-1:0] box_min_y;
        logic signed [CoordW-1:0] box_max_x;
        logic signed [CoordW-1:0] box_max_y;
    } hit_out_t;

    typedef struct packed {
        logic                     selected;
        logic signed [CoordW-1:0] box_min_x;
        logic signed [CoordW-1:0] box_min_y;
        logic signed [CoordW-1:0] box_max_x;
        logic signed [CoordW-1:0] box_max_y;
    } side_t;

    // One queued job: the distance is the largest q with q*q*len2 <= mag*mag,
    // or the square root of mag in point mode.
    typedef struct packed {
        logic            pt_mode;
        logic [MagW-1:0] mag;
        logic [MagW-1:0] len2;
        side_t           side;
    } job_t;

endpackage

// ----- src/lsht_front.sv -----
module lsht_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  lsht_pkg::cfg_t   cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  lsht_pkg::seg_in_t s_data,
    output logic             q_valid,
    input  logic             q_ready,
    output lsht_pkg::job_t   q_job
);
    import lsht_pkg::*;

    logic en;

    logic signed [DiffW-1:0] abx_c, aby_c, apx_c, apy_c, bpx_c, bpy_c;
    logic signed [DiffW-1:0] min_x_c, min_y_c, max_x_c, max_y_c, half_c;
    logic                    sel_c;
    side_t                   side_c;

    logic                    a_valid_reg, a_kind_reg;
    logic signed [DiffW-1:0] a_abx_reg, a_aby_reg, a_apx_reg, a_apy_reg, a_bpx_reg, a_bpy_reg;
    side_t                   a_side_reg;

    logic                    b_valid_reg, b_kind_reg;
    logic signed [ProdW-1:0] b_dax_reg, b_day_reg, b_dbx_reg, b_dby_reg;
    logic signed [ProdW-1:0] b_cx1_reg, b_cx2_reg, b_lx_reg, b_ly_reg;
    logic signed [ProdW-1:0] b_nax_reg, b_nay_reg, b_nbx_reg, b_nby_reg;
    side_t                   b_side_reg;

    logic signed [ProdW:0] dot_a, dot_b, cross_s;
    logic [MagW-1:0]       cross_abs, len2, na, nb;
    job_t                  job_c;

    logic c_valid_reg;
    job_t c_job_reg;

    function automatic logic signed [CoordW-1:0] sat24(input logic signed [DiffW-1:0] v);
        if (v > DiffW'(CoordMax)) begin
            return CoordMax;
        end else if (v < DiffW'(CoordMin)) begin
            return CoordMin;
        end
        return v[CoordW-1:0];
    endfunction

    function automatic logic between(input logic signed [CoordW-1:0] v,
                                     input logic signed [CoordW-1:0] a,
                                     input logic signed [CoordW-1:0] b);
        return (v < a && v > b) || (v > a && v < b);
    endfunction

    assign en      = !c_valid_reg || q_ready;
    assign s_ready = en;
    assign q_valid = c_valid_reg;
    assign q_job   = c_job_reg;

    always_comb begin
        abx_c = {s_data.end_x[CoordW-1], s_data.end_x} - {s_data.start_x[CoordW-1], s_data.start_x};
        aby_c = {s_data.end_y[CoordW-1], s_data.end_y} - {s_data.start_y[CoordW-1], s_data.start_y};
        apx_c = {cfg.cursor_x[CoordW-1], cfg.cursor_x} - {s_data.start_x[CoordW-1], s_data.start_x};
        apy_c = {cfg.cursor_y[CoordW-1], cfg.cursor_y} - {s_data.start_y[CoordW-1], s_data.start_y};
        bpx_c = {cfg.cursor_x[CoordW-1], cfg.cursor_x} - {s_data.end_x[CoordW-1], s_data.end_x};
        bpy_c = {cfg.cursor_y[CoordW-1], cfg.cursor_y} - {s_data.end_y[CoordW-1], s_data.end_y};

        half_c  = $signed({{(DiffW-ThickW+1){1'b0}}, s_data.thickness[ThickW-1:1]});
        min_x_c = (s_data.start_x < s_data.end_x) ? DiffW'(s_data.start_x) : DiffW'(s_data.end_x);
        min_y_c = (s_data.start_y < s_data.end_y) ? DiffW'(s_data.start_y) : DiffW'(s_data.end_y);
        max_x_c = (s_data.start_x > s_data.end_x) ? DiffW'(s_data.start_x) : DiffW'(s_data.end_x);
        max_y_c = (s_data.start_y > s_data.end_y) ? DiffW'(s_data.start_y) : DiffW'(s_data.end_y);

        sel_c = (between(s_data.start_x, cfg.sel_a_x, cfg.sel_b_x) &&
                 between(s_data.start_y, cfg.sel_a_y, cfg.sel_b_y)) ||
                (between(s_data.end_x, cfg.sel_a_x, cfg.sel_b_x) &&
                 between(s_data.end_y, cfg.sel_a_y, cfg.sel_b_y));

        side_c = '0;
        if (s_data.kind) begin
            side_c.selected  = sel_c;
            side_c.box_min_x = sat24(min_x_c - half_c);
            side_c.box_min_y = sat24(min_y_c - half_c);
            side_c.box_max_x = sat24(max_x_c + half_c);
            side_c.box_max_y = sat24(max_y_c + half_c);
        end
    end

    always_comb begin
        dot_a     = {b_dax_reg[ProdW-1], b_dax_reg} + {b_day_reg[ProdW-1], b_day_reg};
        dot_b     = {b_dbx_reg[ProdW-1], b_dbx_reg} + {b_dby_reg[ProdW-1], b_dby_reg};
        cross_s   = {b_cx1_reg[ProdW-1], b_cx1_reg} - {b_cx2_reg[ProdW-1], b_cx2_reg};
        cross_abs = cross_s[ProdW] ? MagW'(-cross_s) : MagW'(cross_s);
        len2      = MagW'($unsigned(b_lx_reg)) + MagW'($unsigned(b_ly_reg));
        na        = MagW'($unsigned(b_nax_reg)) + MagW'($unsigned(b_nay_reg));
        nb        = MagW'($unsigned(b_nbx_reg)) + MagW'($unsigned(b_nby_reg));

        job_c.side    = b_side_reg;
        job_c.pt_mode = 1'b1;
        job_c.len2    = MagW'(1);
        job_c.mag     = '0;
        if (!b_kind_reg) begin
            job_c.mag = '0;
        end else if (len2 == '0 || dot_a[ProdW]) begin
            job_c.mag = na;
        end else if (!dot_b[ProdW] && dot_b != '0) begin
            // Cursor lies beyond the end point.
            job_c.mag = nb;
        end else begin
            job_c.pt_mode = 1'b0;
            job_c.mag     = cross_abs;
            job_c.len2    = len2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_kind_reg <= s_data.kind;
            a_abx_reg  <= abx_c;
            a_aby_reg  <= aby_c;
            a_apx_reg  <= apx_c;
            a_apy_reg  <= apy_c;
            a_bpx_reg  <= bpx_c;
            a_bpy_reg  <= bpy_c;
            a_side_reg <= side_c;

            b_kind_reg <= a_kind_reg;
            b_side_reg <= a_side_reg;
            b_dax_reg  <= a_abx_reg * a_apx_reg;
            b_day_reg  <= a_aby_reg * a_apy_reg;
            b_dbx_reg  <= a_abx_reg * a_bpx_reg;
            b_dby_reg  <= a_aby_reg * a_bpy_reg;
            b_cx1_reg  <= a_abx_reg * a_apy_reg;
            b_cx2_reg  <= a_aby_reg * a_apx_reg;
            b_lx_reg   <= a_abx_reg * a_abx_reg;
            b_ly_reg   <= a_aby_reg * a_aby_reg;
            b_nax_reg  <= a_apx_reg * a_apx_reg;
            b_nay_reg  <= a_apy_reg * a_apy_reg;
            b_nbx_reg  <= a_bpx_reg * a_bpx_reg;
            b_nby_reg  <= a_bpy_reg * a_bpy_reg;

            c_job_reg  <= job_c;
        end
    end

endmodule

// ----- src/lsht_queue.sv -----
module lsht_queue #(
    parameter int DEPTH = lsht_pkg::LSHT_QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  lsht_pkg::job_t in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output lsht_pkg::job_t out_job
);
    import lsht_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    job_t            mem_reg [0:DEPTH-1];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            push, pop;

    assign in_ready  = count_reg != CntW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// ----- src/lsht_back.sv -----
module lsht_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_valid,
    output logic               job_ready,
    input  lsht_pkg::job_t     job,
    output logic               m_valid,
    input  logic               m_ready,
    output lsht_pkg::hit_out_t m_data
);
    import lsht_pkg::*;

    localparam int Steps = DistW;
    localparam int HalfW = MagW / 2;

    logic en;

    logic            z_valid_reg, z_pt_reg;
    logic [MagW-1:0] z_mag_reg, z_len2_reg;
    logic [MagW-1:0] z_hh_reg, z_hl_reg, z_ll_reg;
    side_t           z_side_reg;

    logic             it_valid_reg [0:Steps];
    logic [RemW-1:0]  it_r_reg     [0:Steps];
    logic [AccW-1:0]  it_m_reg     [0:Steps];
    logic [MagW-1:0]  it_l_reg     [0:Steps];
    logic [DistW-1:0] it_q_reg     [0:Steps];
    side_t            it_side_reg  [0:Steps];

    logic [RemW-1:0]  r_init;
    logic [RemW-1:0]  cand   [0:Steps-1];
    logic             take   [0:Steps-1];
    logic [RemW-1:0]  r_next [0:Steps-1];
    logic [AccW-1:0]  m_next [0:Steps-1];
    logic [DistW-1:0] q_next [0:Steps-1];

    assign en        = !m_valid || m_ready;
    assign job_ready = en;
    assign m_valid   = it_valid_reg[Steps];

    always_comb begin
        m_data.distance  = it_q_reg[Steps];
        m_data.selected  = it_side_reg[Steps].selected;
        m_data.box_min_x = it_side_reg[Steps].box_min_x;
        m_data.box_min_y = it_side_reg[Steps].box_min_y;
        m_data.box_max_x = it_side_reg[Steps].box_max_x;
        m_data.box_max_y = it_side_reg[Steps].box_max_y;
    end

    // Squared magnitude from three partial products, or the magnitude itself in point mode.
    always_comb begin
        if (z_pt_reg) begin
            r_init = RemW'(z_mag_reg);
        end else begin
            r_init = (RemW'(z_hh_reg) << (2 * HalfW)) + (RemW'(z_hl_reg) << (HalfW + 1))
                   + RemW'(z_ll_reg);
        end
    end

    // Each step keeps R = mag^2 - len2*q^2 (mag - q^2 in point mode) and M = len2*q, so trying one more
    // result bit only needs shifted copies of M and len2.
    always_comb begin
        for (int i = 0; i < Steps; i++) begin
            cand[i]   = (RemW'(it_m_reg[i]) << (Steps - i))
                      + (RemW'(it_l_reg[i]) << (2 * (Steps - 1 - i)));
            take[i]   = it_r_reg[i] >= cand[i];
            r_next[i] = take[i] ? it_r_reg[i] - cand[i] : it_r_reg[i];
            m_next[i] = take[i] ? it_m_reg[i] + (AccW'(it_l_reg[i]) << (Steps - 1 - i))
                                : it_m_reg[i];
            q_next[i] = take[i] ? it_q_reg[i] | (DistW'(1) << (Steps - 1 - i)) : it_q_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_valid_reg <= 1'b0;
            for (int i = 0; i <= Steps; i++) begin
                it_valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            z_valid_reg     <= job_valid;
            it_valid_reg[0] <= z_valid_reg;
            for (int i = 0; i < Steps; i++) begin
                it_valid_reg[i+1] <= it_valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_pt_reg   <= job.pt_mode;
            z_mag_reg  <= job.mag;
            z_len2_reg <= job.len2;
            z_side_reg <= job.side;
            z_hh_reg   <= MagW'(job.mag[MagW-1:HalfW] * job.mag[MagW-1:HalfW]);
            z_hl_reg   <= MagW'(job.mag[MagW-1:HalfW] * job.mag[HalfW-1:0]);
            z_ll_reg   <= MagW'(job.mag[HalfW-1:0] * job.mag[HalfW-1:0]);

            it_r_reg[0]    <= r_init;
            it_m_reg[0]    <= '0;
            it_l_reg[0]    <= z_len2_reg;
            it_q_reg[0]    <= '0;
            it_side_reg[0] <= z_side_reg;
            for (int i = 0; i < Steps; i++) begin
                it_r_reg[i+1]    <= r_next[i];
                it_m_reg[i+1]    <= m_next[i];
                it_l_reg[i+1]    <= it_l_reg[i];
                it_q_reg[i+1]    <= q_next[i];
                it_side_reg[i+1] <= it_side_reg[i];
            end
        end
    end

endmodule

// ----- src/line_segment_hit_test_unit.sv -----
// Line segment hit test.
// The cursor point and the two selection corners are loaded through the plain
// write port (cfg_we, cfg_index, cfg_wdata); the user must load them only while
// the unit is idle, as the block does not enforce it. Index 0 is cursor x, 1
// cursor y, 2 and 3 the first corner, 4 and 5 the second corner. Other indexes
// are ignored. All six registers clear to zero at reset. Each word on the s_
// channel is one segment; each word on the m_ channel is its result: cursor
// distance, selection flag and the grown bounding box. Throughput is one word
// per cycle while m_ready stays high. A word passes 31 register stages: three
// front stages (differences, products, classification), one in the job queue,
// two forming the squared magnitude, and one per result bit of the 25-bit
// distance root. When m_ready is low while m_valid is high, the back pipeline
// holds; the job queue then fills and the front stalls, dropping s_ready.
// Nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and the queue.
module line_segment_hit_test_unit #(
    parameter int QUEUE_DEPTH = lsht_pkg::LSHT_QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lsht_pkg::CfgIndexW-1:0]  cfg_index,
    input  logic [lsht_pkg::CoordW-1:0]     cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  lsht_pkg::seg_in_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output lsht_pkg::hit_out_t              m_data
);
    import lsht_pkg::*;

    cfg_t cfg_reg;
    logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    job_t q_in_job, q_out_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CURSOR_X: cfg_reg.cursor_x <= cfg_wdata;
                REG_CURSOR_Y: cfg_reg.cursor_y <= cfg_wdata;
                REG_SEL_A_X:  cfg_reg.sel_a_x  <= cfg_wdata;
                REG_SEL_A_Y:  cfg_reg.sel_a_y  <= cfg_wdata;
                REG_SEL_B_X:  cfg_reg.sel_b_x  <= cfg_wdata;
                REG_SEL_B_Y:  cfg_reg.sel_b_y  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    lsht_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_in_valid),
        .q_ready (q_in_ready),
        .q_job   (q_in_job)
    );

    lsht_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_job    (q_in_job),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_job   (q_out_job)
    );

    lsht_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_out_valid),
        .job_ready (q_out_ready),
        .job       (q_out_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- tb/tb_line_segment_hit_test_unit.sv -----
module tb_line_segment_hit_test_unit;
    import lsht_pkg::*;

    localparam logic [CfgIndexW-1:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [CfgIndexW-1:0] SPARE_INDEX_HI = 3'd7;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1000;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_we;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CoordW-1:0]  cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    seg_in_t            s_data;
    logic               m_valid;
    logic               m_ready = 1'b0;
    hit_out_t           m_data;

    bit no_idle;
    int stall_left = 0;

    line_segment_hit_test_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    class hit_scoreboard;
        longint cur_x, cur_y, sa_x, sa_y, sb_x, sb_y;
        hit_out_t pending_hits[$];
        int errors;
        int checked;
        int selected_seen;

        function void set_reg(logic [CfgIndexW-1:0] idx, logic [CoordW-1:0] val);
            longint v;
            v = longint'($signed(val));
            case (idx)
                REG_CURSOR_X: cur_x = v;
                REG_CURSOR_Y: cur_y = v;
                REG_SEL_A_X:  sa_x = v;
                REG_SEL_A_Y:  sa_y = v;
                REG_SEL_B_X:  sb_x = v;
                REG_SEL_B_Y:  sb_y = v;
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r, t;
            r = 0;
            for (int b = DistW - 1; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= n) r = t;
            end
            return r;
        endfunction

        // Largest q with q*q*len2 <= cross_m*cross_m, done in 128 bits.
        function longint unsigned perp_floor(longint unsigned cross_m, longint unsigned len2);
            bit [127:0] cc, lhs;
            longint unsigned q, t;
            q = 0;
            cc = 128'(cross_m) * 128'(cross_m);
            for (int b = DistW - 1; b >= 0; b--) begin
                t = q | (64'd1 << b);
                lhs = 128'(t) * 128'(t) * 128'(len2);
                if (lhs <= cc) q = t;
            end
            return q;
        endfunction

        function bit strictly_between(longint v, longint a, longint b);
            return (v < a && v > b) || (v > a && v < b);
        endfunction

        function logic [CoordW-1:0] clamp_coord(longint v);
            if (v > 64'sd8388607) return CoordMax;
            if (v < -64'sd8388608) return CoordMin;
            return v[CoordW-1:0];
        endfunction

        function hit_out_t segment_hit(seg_in_t s);
            hit_out_t h;
            longint ax, ay, bx, by, half, abx, aby, apx, apy, bpx, bpy, cross_m;
            longint unsigned dist_q;
            h = '0;
            if (!s.kind) return h;
            ax = longint'($signed(s.start_x));
            ay = longint'($signed(s.start_y));
            bx = longint'($signed(s.end_x));
            by = longint'($signed(s.end_y));
            half = longint'(s.thickness >> 1);
            abx = bx - ax; aby = by - ay;
            apx = cur_x - ax; apy = cur_y - ay;
            bpx = cur_x - bx; bpy = cur_y - by;
            if ((abx == 0 && aby == 0) || abx * apx + aby * apy < 0)
                dist_q = root_floor(apx * apx + apy * apy);
            else if ((-abx) * bpx + (-aby) * bpy < 0)
                dist_q = root_floor(bpx * bpx + bpy * bpy);
            else begin
                cross_m = abx * apy - aby * apx;
                if (cross_m < 0) cross_m = -cross_m;
                dist_q = perp_floor(cross_m, abx * abx + aby * aby);
            end
            h.distance = dist_q[DistW-1:0];
            h.selected = (strictly_between(ax, sa_x, sb_x) && strictly_between(ay, sa_y, sb_y))
                      || (strictly_between(bx, sa_x, sb_x) && strictly_between(by, sa_y, sb_y));
            h.box_min_x = clamp_coord((ax < bx ? ax : bx) - half);
            h.box_min_y = clamp_coord((ay < by ? ay : by) - half);
            h.box_max_x = clamp_coord((ax > bx ? ax : bx) + half);
            h.box_max_y = clamp_coord((ay > by ? ay : by) + half);
            return h;
        endfunction

        function void note_segment(seg_in_t s);
            pending_hits.push_back(segment_hit(s));
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch on %s at %0t: got %0h expected %0h", what, $time, got, want);
            errors++;
        endtask

        task check_hit(hit_out_t got);
            hit_out_t want;
            if (pending_hits.size() == 0) begin
                report("unexpected word", longint'(got.distance), 0);
                return;
            end
            want = pending_hits.pop_front();
            checked++;
            if (want.selected) selected_seen++;
            if (got.distance !== want.distance) report("distance", got.distance, want.distance);
            if (got.selected !== want.selected) report("selected", got.selected, want.selected);
            if (got.box_min_x !== want.box_min_x) report("box_min_x", got.box_min_x, want.box_min_x);
            if (got.box_min_y !== want.box_min_y) report("box_min_y", got.box_min_y, want.box_min_y);
            if (got.box_max_x !== want.box_max_x) report("box_max_x", got.box_max_x, want.box_max_x);
            if (got.box_max_y !== want.box_max_y) report("box_max_y", got.box_max_y, want.box_max_y);
        endtask
    endclass

    hit_scoreboard hits = new();

    function int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sink side: random back-pressure, checked at every accepted word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) hits.check_hit(m_data);
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                stall_left <= idle_len();
                m_ready <= 1'b1;
            end
        end
    end

    task write_reg(logic [CfgIndexW-1:0] idx, logic [CoordW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        hits.set_reg(idx, val);
        @(posedge aclk);
    endtask

    task load_cfg(logic [CoordW-1:0] cx, cy, ax, ay, bx, by);
        s_valid <= 1'b0;
        while (hits.pending_hits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(REG_CURSOR_X, cx);
        write_reg(REG_CURSOR_Y, cy);
        write_reg(REG_SEL_A_X, ax);
        write_reg(REG_SEL_A_Y, ay);
        write_reg(REG_SEL_B_X, bx);
        write_reg(REG_SEL_B_Y, by);
        write_reg(SPARE_INDEX_LO, 24'hABCDEF);
        write_reg(SPARE_INDEX_HI, 24'h123456);
        cfg_we <= 1'b0;
    endtask

    task send_segment(seg_in_t s);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= s;
        do @(posedge aclk); while (!s_ready);
        hits.note_segment(s);
    endtask

    function seg_in_t make_seg(logic k, longint sx, sy, ex, ey, logic [ThickW-1:0] th);
        seg_in_t s;
        s.kind = k;
        s.start_x = sx[CoordW-1:0];
        s.start_y = sy[CoordW-1:0];
        s.end_x = ex[CoordW-1:0];
        s.end_y = ey[CoordW-1:0];
        s.thickness = th;
        return s;
    endfunction

    function logic [CoordW-1:0] pick_coord(int spread);
        case ($urandom_range(0, 9))
            0: return CoordMax;
            1: return CoordMin;
            2, 3: return CoordW'($urandom);
            default: return CoordW'($signed($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    task random_burst(int count, int spread);
        seg_in_t s;
        for (int i = 0; i < count; i++) begin
            s.kind = ($urandom_range(0, 9) != 0);
            s.start_x = pick_coord(spread);
            s.start_y = pick_coord(spread);
            // Some zero-length segments.
            if ($urandom_range(0, 19) == 0) begin
                s.end_x = s.start_x;
                s.end_y = s.start_y;
            end else begin
                s.end_x = pick_coord(spread);
                s.end_y = pick_coord(spread);
            end
            s.thickness = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
            send_segment(s);
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_data <= '0;
        no_idle = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_cfg(24'd0, 24'd0, -24'sd2560, -24'sd2560, 24'sd2560, 24'sd2560);
        send_segment(make_seg(1'b0, 100, -200, 300, 400, 16'hFFFF));
        send_segment(make_seg(1'b1, 512, 768, 512, 768, 16'd0));
        send_segment(make_seg(1'b1, 256, 0, 1024, 0, 16'd3));
        send_segment(make_seg(1'b1, -1024, 0, -256, 0, 16'd1));
        send_segment(make_seg(1'b1, -1024, 256, 1024, 256, 16'd512));
        send_segment(make_seg(1'b1, -1000, -700, 1300, 900, 16'd77));
        send_segment(make_seg(1'b1, 2560, 0, 2560, 100, 16'd0));
        send_segment(make_seg(1'b1, 0, 2560, 3000, 3000, 16'd0));
        send_segment(make_seg(1'b1, 2559, 2559, 9000, 9000, 16'd0));
        send_segment(make_seg(1'b1, 8388607, 8388607, -8388608, -8388608, 16'hFFFF));
        send_segment(make_seg(1'b1, -8388608, 8388607, -8388608, 8388607, 16'hFFFF));
        send_segment(make_seg(1'b1, 8388607, -8388608, 8388607, 8388607, 16'h0001));
        send_segment(make_seg(1'b1, -8388608, -8388608, 8388607, -8388608, 16'h8000));

        load_cfg(CoordMax, CoordMin, CoordMin, CoordMax, CoordMax, CoordMin);
        send_segment(make_seg(1'b1, -8388608, 8388607, -8388608, 8388607, 16'd0));
        send_segment(make_seg(1'b1, 0, 0, 10, -10, 16'd0));
        send_segment(make_seg(1'b1, -8388608, -8388608, 8388607, 8388607, 16'hFFFF));
        send_segment(make_seg(1'b1, 8388607, 8388607, 8388607, -8388608, 16'd9));
        send_segment(make_seg(1'b0, -1, -1, -1, -1, 16'hFFFF));

        // Cursor at the far corner, selection box with no height.
        load_cfg(CoordMin, CoordMax, -24'sd100, 24'sd5, 24'sd100, 24'sd5);
        send_segment(make_seg(1'b1, 0, 5, 50, 5, 16'd10));
        send_segment(make_seg(1'b1, 8388607, -8388608, -8388608, 8388607, 16'hFFFF));

        no_idle = 1'b1;
        load_cfg(24'sd300, -24'sd200, 24'sd4000, 24'sd4000, -24'sd4000, -24'sd4000);
        random_burst(150, 6000);
        no_idle = 1'b0;
        random_burst(250, 6000);
        load_cfg(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
                 CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
        random_burst(200, 8000000);
        load_cfg(CoordMax, CoordMax, CoordMin, CoordMin, CoordMax, CoordMax);
        random_burst(150, 100000);
        load_cfg(-24'sd50, 24'sd70, 24'sd1000, -24'sd900, -24'sd1100, 24'sd800);
        random_burst(250, 2000);

        s_valid <= 1'b0;
        while (hits.pending_hits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Checked %0d result words over seven register settings, %0d of them selected.",
                 hits.checked, hits.selected_seen);
        if (hits.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Run timed out with %0d results still pending.", hits.pending_hits.size());
        $display("FAIL");
        $finish;
    end

endmodule
